@@ rtl/core/izhikevich_neuron_update_assert.svh @@
// ----------------------------------------------------------------------------
// izhikevich neuron update assertion macros
// concurrent check templates used by the rtl file that carries assertions
// ----------------------------------------------------------------------------
`ifndef IZHIKEVICH_NEURON_UPDATE_ASSERT_SVH
`define IZHIKEVICH_NEURON_UPDATE_ASSERT_SVH

// same-cycle implication
`define IZH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("izh: same-cycle check failed");

// next-cycle implication
`define IZH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("izh: next-cycle check failed");

`endif

@@ rtl/core/izh_pkg.sv @@
// ----------------------------------------------------------------------------
// izh_pkg
// shared widths, codes, types and saturation helper of the neuron update block
// ----------------------------------------------------------------------------
package izh_pkg;

	localparam int DATA_W      = 32;
	localparam int NEURON_W    = 10;
	localparam int ROW_W       = 3 * DATA_W;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 80;

	localparam int NEURONS_DEF   = 1024;
	localparam int EXCIT_DEF     = 800;
	localparam int FRAC_BITS_DEF = 16;

	localparam int A_W = 17;
	localparam int B_W = 19;
	localparam int C_W = 24;
	localparam int D_W = 22;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_A_EXCIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_A_INHIB = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_B_EXCIT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_B_INHIB = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_C_EXCIT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_C_INHIB = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_D_EXCIT = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_D_INHIB = 3'd7;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam logic [A_W-1:0]        A_EXCIT_RST = 17'd1311;
	localparam logic [A_W-1:0]        A_INHIB_RST = 17'd6554;
	localparam logic signed [B_W-1:0] B_EXCIT_RST = 19'sd13107;
	localparam logic signed [B_W-1:0] B_INHIB_RST = 19'sd13107;
	localparam logic signed [C_W-1:0] C_EXCIT_RST = -24'sd4259840;
	localparam logic signed [C_W-1:0] C_INHIB_RST = -24'sd4259840;
	localparam logic [D_W-1:0]        D_EXCIT_RST = 22'd524288;
	localparam logic [D_W-1:0]        D_INHIB_RST = 22'd131072;

	typedef struct packed {
		logic [A_W-1:0]        a_excit;
		logic [A_W-1:0]        a_inhib;
		logic signed [B_W-1:0] b_excit;
		logic signed [B_W-1:0] b_inhib;
		logic signed [C_W-1:0] c_excit;
		logic signed [C_W-1:0] c_inhib;
		logic [D_W-1:0]        d_excit;
		logic [D_W-1:0]        d_inhib;
	} cfg_set_t;

	typedef struct packed {
		logic [NEURON_W-1:0]      neuron;
		logic                     fired;
		logic signed [DATA_W-1:0] potential;
		logic signed [DATA_W-1:0] recovery;
	} res_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > 64'sh0000_0000_7fff_ffff) begin
			r = 32'sh7fff_ffff;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/izhikevich_neuron_update.sv @@
// ----------------------------------------------------------------------------
// izhikevich_neuron_update
// fixed-point spiking neuron array: per-neuron state memory, current
// accumulation and one-step membrane and recovery update
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_*      in   tuser: operation; tdata: neuron, current_amount
// m_*      out  tdata: neuron_out, fired, potential, recovery
// cfg_*    in   register index, write data
//
// add-current item: memory read, then write back
// update item: memory read, the single shared multiplier used six times in turn, then write back
// after reset every row of the state memory is written with its start values; no item is taken meanwhile
// a result waiting in the output register stalls only the write back of the next update
// ----------------------------------------------------------------------------
`include "izhikevich_neuron_update_assert.svh"

module izhikevich_neuron_update #(
	parameter int NEURONS       = izh_pkg::NEURONS_DEF,
	parameter int EXCIT_NEURONS = izh_pkg::EXCIT_DEF,
	parameter int FRAC_BITS     = izh_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [9:0] neuron, [41:10] current_amount, [47:42] zero
	input  logic [izh_pkg::IN_TDATA_W-1:0]      s_tdata,
	// [0] operation
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [9:0] neuron_out, [10] fired, [42:11] potential, [74:43] recovery, [79:75] zero
	output logic [izh_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [izh_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [izh_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import izh_pkg::*;

	localparam int AW = $clog2(NEURONS);

	cfg_set_t          cfg_set;
	logic [AW-1:0]     ram_raddr, ram_waddr;
	logic [ROW_W-1:0]  ram_rdata, ram_wdata;
	logic              ram_we;
	logic              res_valid, res_ready;
	res_t              res;
	logic              clearing;
	logic              out_valid_q;
	res_t              out_q;

	izh_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (cfg_valid),
		.ready  (cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.regs   (cfg_set)
	);

	// one row per neuron: current, recovery, potential
	izh_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NEURONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	izh_seq #(
		.NEURONS       (NEURONS),
		.EXCIT_NEURONS (EXCIT_NEURONS),
		.FRAC_BITS     (FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_neuron (s_tdata[NEURON_W-1:0]),
		.in_amount (s_tdata[NEURON_W+DATA_W-1:NEURON_W]),
		.cfg       (cfg_set),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.clearing  (clearing)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - NEURON_W - 1 - 2 * DATA_W){1'b0}},
		out_q.recovery, out_q.potential, out_q.fired, out_q.neuron};

	`IZH_ASSERT_IMP(a_clear_blocks_input, clk, arst_n, clearing, !s_tready)
	`IZH_ASSERT_NEXT(a_result_held, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res))
	`IZH_ASSERT_IMP(a_result_writes_back, clk, arst_n, res_valid && res_ready, ram_we)

endmodule

@@ rtl/core/izh_ram.sv @@
// ----------------------------------------------------------------------------
// izh_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module izh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/izh_cfg.sv @@
// ----------------------------------------------------------------------------
// izh_cfg
// excitatory and inhibitory parameter registers behind the config write port
// ----------------------------------------------------------------------------
module izh_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid,
	output logic                               ready,
	input  logic [izh_pkg::CFG_INDEX_W-1:0]    index,
	input  logic [izh_pkg::CFG_DATA_W-1:0]     data,
	output izh_pkg::cfg_set_t                  regs
);

	import izh_pkg::*;

	cfg_set_t regs_q;

	assign ready = 1'b1;
	assign regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.a_excit <= A_EXCIT_RST;
			regs_q.a_inhib <= A_INHIB_RST;
			regs_q.b_excit <= B_EXCIT_RST;
			regs_q.b_inhib <= B_INHIB_RST;
			regs_q.c_excit <= C_EXCIT_RST;
			regs_q.c_inhib <= C_INHIB_RST;
			regs_q.d_excit <= D_EXCIT_RST;
			regs_q.d_inhib <= D_INHIB_RST;
		end else if (valid) begin
			case (index)
				REG_A_EXCIT: regs_q.a_excit <= data[A_W-1:0];
				REG_A_INHIB: regs_q.a_inhib <= data[A_W-1:0];
				REG_B_EXCIT: regs_q.b_excit <= data[B_W-1:0];
				REG_B_INHIB: regs_q.b_inhib <= data[B_W-1:0];
				REG_C_EXCIT: regs_q.c_excit <= data[C_W-1:0];
				REG_C_INHIB: regs_q.c_inhib <= data[C_W-1:0];
				REG_D_EXCIT: regs_q.d_excit <= data[D_W-1:0];
				REG_D_INHIB: regs_q.d_inhib <= data[D_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/izh_mul.sv @@
// ----------------------------------------------------------------------------
// izh_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module izh_mul #(
	parameter int X_W = 37,
	parameter int Y_W = 32
) (
	input  logic                        clk,
	input  logic signed [X_W-1:0]       x,
	input  logic signed [Y_W-1:0]       y,
	output logic signed [X_W+Y_W-1:0]   p
);

	logic signed [X_W+Y_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= x * y;
	end

	assign p = p_q;

endmodule

@@ rtl/core/izh_seq.sv @@
// ----------------------------------------------------------------------------
// izh_seq
// read-modify-write sequencer: memory clear, current accumulation and the
// multi-step neuron update on the shared multiplier
// ----------------------------------------------------------------------------
module izh_seq #(
	parameter int NEURONS       = izh_pkg::NEURONS_DEF,
	parameter int EXCIT_NEURONS = izh_pkg::EXCIT_DEF,
	parameter int FRAC_BITS     = izh_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_op,
	input  logic [izh_pkg::NEURON_W-1:0]      in_neuron,
	input  logic signed [izh_pkg::DATA_W-1:0] in_amount,
	input  izh_pkg::cfg_set_t                 cfg,
	output logic [$clog2(NEURONS)-1:0]        ram_raddr,
	input  logic [izh_pkg::ROW_W-1:0]         ram_rdata,
	output logic                              ram_we,
	output logic [$clog2(NEURONS)-1:0]        ram_waddr,
	output logic [izh_pkg::ROW_W-1:0]         ram_wdata,
	output logic                              res_valid,
	input  logic                              res_ready,
	output izh_pkg::res_t                     res,
	output logic                              clearing
);

	import izh_pkg::*;

	localparam int AW    = $clog2(NEURONS);
	localparam int BVP_W = B_W + DATA_W - FRAC_BITS;
	localparam int BV_W  = ((BVP_W > DATA_W) ? BVP_W : DATA_W) + 1;
	localparam int MX_W  = BV_W;
	localparam int MY_W  = DATA_W;
	localparam int P_W   = MX_W + MY_W;

	localparam longint ONE_Q = longint'(1) << FRAC_BITS;
	localparam logic signed [MY_W-1:0]   K_004    = MY_W'(((4 * ONE_Q) + 50) / 100);
	localparam logic signed [63:0]       K_FIVE   = 5 * ONE_Q;
	localparam logic signed [63:0]       K_140    = 140 * ONE_Q;
	localparam logic signed [63:0]       K_THRESH = 30 * ONE_Q;
	localparam logic signed [DATA_W-1:0] V_START  = DATA_W'(-65 * ONE_Q);
	localparam logic signed [DATA_W-1:0] U_START  = DATA_W'(-13 * ONE_Q);
	localparam logic [AW-1:0]            CLR_LAST = AW'(NEURONS - 1);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_LOAD   = 4'd2;
	localparam logic [3:0] ST_PREP   = 4'd3;
	localparam logic [3:0] ST_HS_K   = 4'd4;
	localparam logic [3:0] ST_HS_T   = 4'd5;
	localparam logic [3:0] ST_HS_TV  = 4'd6;
	localparam logic [3:0] ST_HS_V   = 4'd7;
	localparam logic [3:0] ST_BV     = 4'd8;
	localparam logic [3:0] ST_BV_SUB = 4'd9;
	localparam logic [3:0] ST_ABV    = 4'd10;
	localparam logic [3:0] ST_U_UPD  = 4'd11;
	localparam logic [3:0] ST_WB     = 4'd12;

	logic [3:0]               state_q, state_d;
	logic [AW-1:0]            clr_q;
	logic                     half_q;
	logic                     op_q;
	logic [NEURON_W-1:0]      n_q;
	logic signed [DATA_W-1:0] amt_q;
	logic                     excit_q;
	logic                     fired_q;
	logic signed [DATA_W-1:0] v_q, u_q, cur_q;
	logic signed [63:0]       base_q;
	logic signed [MY_W-1:0]   t_q;
	logic signed [MX_W-1:0]   bv_q;

	logic                     in_range, in_excit;
	logic [AW-1:0]            n_addr;
	logic signed [DATA_W-1:0] row_v, row_u, row_c;
	logic signed [DATA_W-1:0] cur_sum, u_spike;
	logic                     spike;
	logic [A_W-1:0]           sel_a;
	logic signed [B_W-1:0]    sel_b;
	logic signed [C_W-1:0]    sel_c;
	logic [D_W-1:0]           sel_d;
	logic signed [63:0]       d_ext;
	logic signed [MX_W-1:0]   mul_x;
	logic signed [MY_W-1:0]   mul_y;
	logic signed [P_W-1:0]    prod;
	logic signed [63:0]       p_sh, hv;
	logic signed [DATA_W-1:0] v_half, u_next;

	izh_mul #(
		.X_W (MX_W),
		.Y_W (MY_W)
	) u_mul (
		.clk (clk),
		.x   (mul_x),
		.y   (mul_y),
		.p   (prod)
	);

	assign in_range  = {{(32 - NEURON_W){1'b0}}, in_neuron} < 32'(NEURONS);
	assign in_excit  = {{(32 - NEURON_W){1'b0}}, in_neuron} < 32'(EXCIT_NEURONS);
	assign ram_raddr = AW'(in_neuron);
	assign n_addr    = AW'(n_q);
	assign in_ready  = (state_q == ST_IDLE);
	assign clearing  = (state_q == ST_CLEAR);
	assign res_valid = (state_q == ST_WB);

	assign res.neuron    = n_q;
	assign res.fired     = fired_q;
	assign res.potential = v_q;
	assign res.recovery  = u_q;

	// excitatory or inhibitory parameter set
	assign sel_a = excit_q ? cfg.a_excit : cfg.a_inhib;
	assign sel_b = excit_q ? cfg.b_excit : cfg.b_inhib;
	assign sel_c = excit_q ? cfg.c_excit : cfg.c_inhib;
	assign sel_d = excit_q ? cfg.d_excit : cfg.d_inhib;
	assign d_ext = signed'(64'(sel_d));

	assign row_v = ram_rdata[DATA_W-1:0];
	assign row_u = ram_rdata[2*DATA_W-1:DATA_W];
	assign row_c = ram_rdata[3*DATA_W-1:2*DATA_W];

	assign cur_sum = sat32(64'(row_c) + 64'(amt_q));
	assign spike   = 64'(row_v) >= K_THRESH;
	assign u_spike = sat32(64'(row_u) + d_ext);

	// product scaled back to the fixed-point grid, rounding down
	assign p_sh   = 64'(prod >>> FRAC_BITS);
	assign hv     = p_sh + base_q;
	assign v_half = sat32(64'(v_q) + (hv >>> 1));
	assign u_next = sat32(64'(u_q) + p_sh);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = n_addr;
		ram_wdata = {{DATA_W{1'b0}}, u_q, v_q};
		mul_x     = MX_W'(v_q);
		mul_y     = K_004;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = {{DATA_W{1'b0}}, U_START, V_START};
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid && in_range) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (op_q == OP_ADD) begin
					ram_we    = 1'b1;
					ram_wdata = {cur_sum, row_u, row_v};
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_PREP;
				end
			end
			ST_PREP:   state_d = ST_HS_T;
			ST_HS_K:   state_d = ST_HS_T;
			ST_HS_T:   state_d = ST_HS_TV;
			ST_HS_TV: begin
				mul_y   = t_q;
				state_d = ST_HS_V;
			end
			ST_HS_V:   state_d = half_q ? ST_BV : ST_HS_K;
			ST_BV: begin
				mul_y   = MY_W'(sel_b);
				state_d = ST_BV_SUB;
			end
			ST_BV_SUB: state_d = ST_ABV;
			ST_ABV: begin
				mul_x   = bv_q;
				mul_y   = MY_W'(signed'({1'b0, sel_a}));
				state_d = ST_U_UPD;
			end
			ST_U_UPD:  state_d = ST_WB;
			ST_WB: begin
				if (res_ready) begin
					ram_we  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			half_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_PREP) begin
				half_q <= 1'b0;
			end
			if (state_q == ST_HS_V) begin
				half_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q    <= in_op;
				n_q     <= in_neuron;
				amt_q   <= in_amount;
				excit_q <= in_excit;
			end
			ST_LOAD: begin
				fired_q <= spike;
				v_q     <= spike ? DATA_W'(sel_c) : row_v;
				u_q     <= spike ? u_spike : row_u;
				cur_q   <= row_c;
			end
			ST_PREP:   base_q <= K_140 - 64'(u_q) + 64'(cur_q);
			ST_HS_T:   t_q    <= MY_W'(p_sh + K_FIVE);
			ST_HS_V:   v_q    <= v_half;
			ST_BV_SUB: bv_q   <= MX_W'(p_sh - 64'(u_q));
			ST_U_UPD:  u_q    <= u_next;
			default: ;
		endcase
	end

endmodule
